### rtl/core/c2dvw_pkg.sv
// Package: shared types, constants and state codes for the 2D valid window unit
`timescale 1ns / 1ps
package c2dvw_pkg;

  localparam int MaxFilterRows = 8;
  localparam int MaxFilterCols = 8;
  localparam int MaxImageRows  = 1024;
  localparam int MaxImageCols  = 1024;

  localparam int SumW    = 38;
  localparam int PosW    = 10;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] RegFilterRows = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFilterCols = 2'd1;
  localparam logic [CfgIdxW-1:0] RegImageRows  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegImageCols  = 2'd3;

  localparam logic KindWeight = 1'b0;
  localparam logic KindPixel  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [2:0]        weight_row;
    logic [2:0]        weight_col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic [PosW-1:0]        out_row;
    logic [PosW-1:0]        out_col;
    logic                   last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_READ,
    ST_MAC,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_item;
    logic write_weight;
    logic write_pixel;
    logic tap_start;
    logic tap_step;
    logic mac_en;
    logic finish;
    logic advance_pos;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_pixel;
    logic window_done;
    logic last_tap;
  } ctrl_status_t;

endpackage

### rtl/core/c2dvw_ram.sv
// Generic single-port-write RAM with registered read
`timescale 1ns / 1ps
module c2dvw_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/c2dvw_ctrl.sv
// Controller state machine: request sequencing and tap walk control
`timescale 1ns / 1ps
module c2dvw_ctrl
  import c2dvw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_STORE;
      ST_STORE: begin
        if (!status.is_pixel) state_next = ST_IDLE;
        else if (status.window_done) state_next = ST_READ;
        else state_next = ST_IDLE;
      end
      ST_READ:   state_next = ST_MAC;
      ST_MAC:    if (status.last_tap) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take_item = in_valid;
      end
      ST_STORE: begin
        cmd.write_weight = !status.is_pixel;
        cmd.write_pixel = status.is_pixel;
        cmd.tap_start = status.is_pixel && status.window_done;
        cmd.advance_pos = status.is_pixel && !status.window_done;
      end
      ST_READ:   cmd.tap_step = 1'b1;
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        cmd.tap_step = !status.last_tap;
      end
      ST_FINISH: cmd.finish = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.advance_pos = out_ready;
      end
      default: cmd = '0;
    endcase
  end
endmodule

### rtl/core/c2dvw_datapath.sv
// Datapath: config registers, position counters, stores, shared multiply-accumulate
`timescale 1ns / 1ps
module c2dvw_datapath
  import c2dvw_pkg::*;
#(
  parameter int MaxFRows = MaxFilterRows,
  parameter int MaxFCols = MaxFilterCols,
  parameter int MaxIRows = MaxImageRows,
  parameter int MaxICols = MaxImageCols
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  in_item_t            in_item,
  input  ctrl_cmd_t           cmd,
  output ctrl_status_t        status,
  output out_item_t           out_item
);
  localparam int FrW  = $clog2(MaxFRows + 1);
  localparam int FcW  = $clog2(MaxFCols + 1);
  localparam int IrW  = $clog2(MaxIRows + 1);
  localparam int IcW  = $clog2(MaxICols + 1);
  localparam int RowW = $clog2(MaxIRows);
  localparam int ColW = $clog2(MaxICols);
  localparam int LineW = $clog2(MaxFRows) > 0 ? $clog2(MaxFRows) : 1;
  localparam int WDepth = MaxFRows * MaxFCols;
  localparam int WAw = $clog2(WDepth) > 0 ? $clog2(WDepth) : 1;
  localparam int LDepth = (1 << LineW) * MaxICols;
  localparam int LAw = $clog2(LDepth);
  localparam int KW = $clog2(MaxFRows) > 0 ? $clog2(MaxFRows) : 1;
  localparam int LW = $clog2(MaxFCols) > 0 ? $clog2(MaxFCols) : 1;

  logic [3:0]  filter_rows, filter_cols;
  logic [10:0] image_rows, image_cols;
  logic [RowW-1:0] pixel_row;
  logic [ColW-1:0] pixel_col;
  in_item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_rows <= 4'd3;
      filter_cols <= 4'd3;
      image_rows <= 11'd1024;
      image_cols <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        RegFilterRows: filter_rows <= cfg_data[3:0];
        RegFilterCols: filter_cols <= cfg_data[3:0];
        RegImageRows:  image_rows <= cfg_data;
        RegImageCols:  image_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) item <= in_item;
  end

  // Clamped geometry
  logic [FrW-1:0] fr;
  logic [FcW-1:0] fc;
  logic [IrW-1:0] ir;
  logic [IcW-1:0] ic;
  always_comb begin
    fr = (filter_rows == 4'd0) ? FrW'(1) :
         (32'(filter_rows) > MaxFRows) ? FrW'(MaxFRows) : FrW'(filter_rows);
    fc = (filter_cols == 4'd0) ? FcW'(1) :
         (32'(filter_cols) > MaxFCols) ? FcW'(MaxFCols) : FcW'(filter_cols);
    ir = (image_rows == 11'd0) ? IrW'(1) :
         (32'(image_rows) > MaxIRows) ? IrW'(MaxIRows) : IrW'(image_rows);
    ic = (image_cols == 11'd0) ? IcW'(1) :
         (32'(image_cols) > MaxICols) ? IcW'(MaxICols) : IcW'(image_cols);
  end

  // Wrapped position of the held pixel
  logic [RowW-1:0] cur_row;
  logic [ColW-1:0] cur_col;
  logic row_end, col_end;
  always_comb begin
    if (32'(pixel_row) >= 32'(ir) || 32'(pixel_col) >= 32'(ic)) begin
      cur_row = '0;
      cur_col = '0;
    end else begin
      cur_row = pixel_row;
      cur_col = pixel_col;
    end
    row_end = (32'(cur_row) + 1 == 32'(ir));
    col_end = (32'(cur_col) + 1 == 32'(ic));
  end

  logic window_done;
  assign window_done = (32'(cur_row) + 1 >= 32'(fr)) && (32'(cur_col) + 1 >= 32'(fc));
  assign status.is_pixel = (item.kind == KindPixel);
  assign status.window_done = window_done;

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index <= RegImageCols)) begin
      pixel_row <= '0;
      pixel_col <= '0;
    end else if (cmd.advance_pos) begin
      if (col_end) begin
        pixel_col <= '0;
        pixel_row <= row_end ? '0 : cur_row + 1'b1;
      end else begin
        pixel_row <= cur_row;
        pixel_col <= cur_col + 1'b1;
      end
    end
  end

  // Output origin
  logic [RowW-1:0] orow;
  logic [ColW-1:0] ocol;
  assign orow = RowW'(32'(cur_row) + 1 - 32'(fr));
  assign ocol = ColW'(32'(cur_col) + 1 - 32'(fc));

  // Tap walk
  logic [KW-1:0] tk;
  logic [LW-1:0] tl;
  logic tap_last;
  assign tap_last = (32'(tk) + 1 == 32'(fr)) && (32'(tl) + 1 == 32'(fc));
  always_ff @(posedge clk) begin
    if (cmd.tap_start) begin
      tk <= '0;
      tl <= '0;
    end else if (cmd.tap_step && !tap_last) begin
      if (32'(tl) + 1 == 32'(fc)) begin
        tl <= '0;
        tk <= tk + 1'b1;
      end else begin
        tl <= tl + 1'b1;
      end
    end
  end

  // Mark the tap whose read data arrives next cycle
  logic rd_last;
  always_ff @(posedge clk) begin
    if (rst || cmd.tap_start) rd_last <= 1'b0;
    else if (cmd.tap_step) rd_last <= tap_last;
  end
  assign status.last_tap = rd_last;

  // Store addresses; a line slot is picked by the low row bits
  logic [WAw-1:0] w_waddr, w_raddr;
  logic [LAw-1:0] l_waddr, l_raddr;
  logic [LineW-1:0] wline, rline;
  logic [RowW-1:0] trow;
  logic w_we;
  assign w_we = cmd.write_weight && (32'(item.weight_row) < MaxFRows)
                && (32'(item.weight_col) < MaxFCols);
  assign w_waddr = WAw'(32'(item.weight_row) * MaxFCols + 32'(item.weight_col));
  assign w_raddr = WAw'(32'(tk) * MaxFCols + 32'(tl));
  assign trow = orow + RowW'(tk);
  assign wline = LineW'(cur_row);
  assign rline = LineW'(trow);
  assign l_waddr = LAw'(32'(wline) * MaxICols + 32'(cur_col));
  assign l_raddr = LAw'(32'(rline) * MaxICols + 32'(ocol) + 32'(tl));

  logic [15:0] w_rdata, l_rdata;
  c2dvw_ram #(.Width(16), .Depth(WDepth)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(item.value),
    .raddr(w_raddr), .rdata(w_rdata)
  );
  c2dvw_ram #(.Width(16), .Depth(LDepth)) u_lram (
    .clk(clk), .we(cmd.write_pixel), .waddr(l_waddr), .wdata(item.value),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // Product register, then accumulate
  logic signed [31:0] prod;
  logic prod_vld;
  logic signed [SumW-1:0] acc;
  always_ff @(posedge clk) begin
    prod <= $signed(w_rdata) * $signed(l_rdata);
    if (rst || cmd.tap_start) prod_vld <= 1'b0;
    else prod_vld <= cmd.mac_en;
    if (cmd.tap_start) acc <= '0;
    else if (prod_vld) acc <= acc + SumW'(prod);
  end

  // Drain the final product and latch the result
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.sum <= acc + (prod_vld ? SumW'(prod) : '0);
      out_item.out_row <= PosW'(orow);
      out_item.out_col <= PosW'(ocol);
      out_item.last <= row_end && col_end;
    end
  end
endmodule

### rtl/core/conv2d_valid_window_unit.sv
// Top level of the 2D valid cross-correlation window unit
`timescale 1ns / 1ps
// Usage:
//   Requests arrive on in_valid/in_ready with payload in_item. Kind 0 writes
//   one filter weight; kind 1 is the next image pixel in raster order.
//   Results leave on out_valid/out_ready with payload out_item: the window
//   sum (signed 38-bit integer), output row and column, and a last-of-image flag.
//   Config: cfg_we, cfg_index, cfg_data; any write restarts the image.
//   Sequence: a weight write or a pixel that completes no window passes
//   through the idle and store states only. A completing pixel goes on
//   through read, multiply-accumulate, finish and output, as the one shared
//   multiplier walks every tap through the weight and line RAM read ports.
//   One request is in flight at a time; while a result waits on out_ready
//   the block holds it and takes no new request.
//   Reset clears the registers to a 3x3 filter on a 1024x1024 image and the
//   pixel position to zero; weight and line RAM contents are not cleared.
module conv2d_valid_window_unit
  import c2dvw_pkg::*;
#(
  parameter int MaxFRows = MaxFilterRows,
  parameter int MaxFCols = MaxFilterCols,
  parameter int MaxIRows = MaxImageRows,
  parameter int MaxICols = MaxImageCols
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item
);
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  c2dvw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
  );

  c2dvw_datapath #(
    .MaxFRows(MaxFRows), .MaxFCols(MaxFCols),
    .MaxIRows(MaxIRows), .MaxICols(MaxICols)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .status(status),
    .out_item(out_item)
  );

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_out_after_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("result not presented after finish");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("pending result changed");
endmodule

### dv/tb_top.sv
// Testbench for the 2D valid window unit: predicts window sums and checks every result
`timescale 1ns / 1ps
module tb_top;
  import c2dvw_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 100;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;

  conv2d_valid_window_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // Predictor state
  logic [3:0]         filt_rows_reg, filt_cols_reg;
  logic [10:0]        img_rows_reg, img_cols_reg;
  logic signed [15:0] coeffs [0:MaxFilterRows*MaxFilterCols-1];
  logic signed [15:0] lines [0:MaxFilterRows*MaxImageCols-1];
  int unsigned        pos_row, pos_col;

  out_item_t sum_queue[$];
  int        mismatches;
  int        cycle_count;
  int        items_sent;
  bit        no_gaps;
  int        rx_hold;
  int        rx_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_window(input in_item_t it);
    int unsigned fr, fc, ir, ic, orow, ocol, base;
    longint acc;
    out_item_t res;
    fr = clamp_to(filt_rows_reg, MaxFilterRows);
    fc = clamp_to(filt_cols_reg, MaxFilterCols);
    ir = clamp_to(img_rows_reg, MaxImageRows);
    ic = clamp_to(img_cols_reg, MaxImageCols);
    if (it.kind == KindWeight) begin
      coeffs[it.weight_row * MaxFilterCols + it.weight_col] = it.value;
      return;
    end
    if (pos_row >= ir || pos_col >= ic) begin
      pos_row = 0;
      pos_col = 0;
    end
    lines[(pos_row % MaxFilterRows) * MaxImageCols + pos_col] = it.value;
    if (pos_row + 1 >= fr && pos_col + 1 >= fc) begin
      orow = pos_row + 1 - fr;
      ocol = pos_col + 1 - fc;
      acc = 0;
      for (int k = 0; k < fr; k++) begin
        base = ((orow + k) % MaxFilterRows) * MaxImageCols;
        for (int l = 0; l < fc; l++)
          acc += longint'(coeffs[k * MaxFilterCols + l]) * longint'(lines[base + ocol + l]);
      end
      res.sum = acc[SumW-1:0];
      res.out_row = orow[PosW-1:0];
      res.out_col = ocol[PosW-1:0];
      res.last = (pos_row + 1 == ir && pos_col + 1 == ic);
      sum_queue.push_back(res);
    end
    if (pos_col + 1 >= ic) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= ir) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  // Drive one request and hold it until the block takes it
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    predict_window(it);
    items_sent++;
  endtask

  task automatic send_pixel(input logic signed [15:0] v);
    in_item_t it;
    it.kind = KindPixel;
    it.weight_row = 3'($urandom);
    it.weight_col = 3'($urandom);
    it.value = v;
    send_item(it);
  endtask

  task automatic send_weight(input int r, input int c, input logic signed [15:0] v);
    in_item_t it;
    it.kind = KindWeight;
    it.weight_row = r[2:0];
    it.weight_col = c[2:0];
    it.value = v;
    send_item(it);
  endtask

  // Drop valid and let the block drain before touching registers
  task automatic wait_idle();
    @(posedge clk);
    in_valid <= 1'b0;
    wait (sum_queue.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CfgDataW-1:0];
    case (idx)
      RegFilterRows: filt_rows_reg = v[3:0];
      RegFilterCols: filt_cols_reg = v[3:0];
      RegImageRows:  img_rows_reg = v[10:0];
      default:       img_cols_reg = v[10:0];
    endcase
    pos_row = 0;
    pos_col = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_shape(input int unsigned fr, input int unsigned fc,
                           input int unsigned ir, input int unsigned ic);
    wait_idle();
    write_reg(RegFilterRows, fr);
    write_reg(RegFilterCols, fc);
    write_reg(RegImageRows, ir);
    write_reg(RegImageCols, ic);
  endtask

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Every weight gets written so no window ever reads an unset tap
  task automatic test_weight_load();
    for (int r = 0; r < MaxFilterRows; r++)
      for (int c = 0; c < MaxFilterCols; c++)
        send_weight(r, c, ((r + c) % 3 == 0) ? 16'sh8000 : 16'($urandom));
    // Reset shape: 3x3 filter on a full image; first row gives no result
    for (int i = 0; i < 10; i++) send_pixel(rand_value());
  endtask

  task automatic test_extremes();
    set_shape(2, 2, 3, 3);
    send_weight(0, 0, 16'sh8000);
    send_weight(0, 1, 16'sh7fff);
    send_weight(1, 0, 16'sh8000);
    send_weight(1, 1, 16'sh8000);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 16'sh7fff : 16'sh8000);
    // Weight update in the middle of an image leaves the position alone
    for (int i = 0; i < 4; i++) send_pixel(16'sh8000);
    send_weight(1, 1, 16'sh7fff);
    for (int i = 0; i < 5; i++) send_pixel(rand_value());
  endtask

  task automatic test_filter_too_big();
    set_shape(4, 2, 2, 5);
    for (int i = 0; i < 12; i++) send_pixel(rand_value());
    set_shape(1, 8, 3, 7);
    for (int i = 0; i < 8; i++) send_pixel(rand_value());
  endtask

  task automatic test_clamped_regs();
    // 0 -> 1 for filters, 15 -> 8
    set_shape(0, 15, 2, 9);
    for (int i = 0; i < 20; i++) send_pixel(rand_value());
    set_shape(9, 0, 9, 3);
    for (int i = 0; i < 28; i++) send_pixel(rand_value());
    // Image registers at both clamp ends; only part of each image is sent
    set_shape(1, 1, 0, 2047);
    for (int i = 0; i < 10; i++) send_pixel(rand_value());
    set_shape(1, 2, 2047, 0);
    for (int i = 0; i < 6; i++) send_pixel(rand_value());
  endtask

  // Hold the receiver off so the first result blocks further requests
  task automatic test_full_filter();
    set_shape(8, 8, 8, 9);
    rx_hold = 400;
    for (int i = 0; i < 72; i++) send_pixel(rand_value());
  endtask

  task automatic test_random(input int target);
    int unsigned fr, fc, ir, ic, n;
    int phase;
    phase = 0;
    while (items_sent < target) begin
      fr = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(1, 4);
      fc = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(1, 4);
      if ($urandom_range(0, 15) == 0) fr = $urandom_range(9, 15);
      if ($urandom_range(0, 15) == 0) fc = 0;
      ir = $urandom_range((fr > 9 ? 8 : fr) - 1, 12);
      ic = $urandom_range((fc == 0 ? 1 : (fc > 8 ? 8 : fc)) - 1, 12);
      if (ir == 0) ir = 1;
      if (ic == 0) ic = 1;
      set_shape(fr, fc, ir, ic);
      no_gaps = (phase % 5 == 2);
      if (phase == 3) rx_hold = 400;
      n = ir * ic * $urandom_range(1, 2) + $urandom_range(0, ic);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_weight($urandom_range(0, 7), $urandom_range(0, 7), rand_value());
        else
          send_pixel(rand_value());
      end
      no_gaps = 1'b0;
      phase++;
    end
  endtask

  // Receiver: random stalls after each result, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall--;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready) rx_stall = no_gaps ? 0 : $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (sum_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        exp_res = sum_queue.pop_front();
        if (out_item.sum !== exp_res.sum || out_item.out_row !== exp_res.out_row ||
            out_item.out_col !== exp_res.out_col || out_item.last !== exp_res.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sum %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                     exp_res.sum, exp_res.out_row, exp_res.out_col, exp_res.last,
                     out_item.sum, out_item.out_row, out_item.out_col, out_item.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegFilterRows;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    items_sent = 0;
    no_gaps = 1'b0;
    rx_hold = 0;
    rx_stall = 0;
    filt_rows_reg = 4'd3;
    filt_cols_reg = 4'd3;
    img_rows_reg = 11'd1024;
    img_cols_reg = 11'd1024;
    pos_row = 0;
    pos_col = 0;
    for (int i = 0; i < MaxFilterRows * MaxFilterCols; i++) coeffs[i] = '0;
    for (int i = 0; i < MaxFilterRows * MaxImageCols; i++) lines[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_weight_load();
    test_extremes();
    test_filter_too_big();
    test_clamped_regs();
    test_full_filter();
    test_random(1300);
    wait_idle();
    if (mismatches == 0 && sum_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
